/* rtl/qkp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkp_pkg
// Shared types, register indexes and phase tables for the quadrature knob
// position decoder.
// ----------------------------------------------------------------------------
package qkp_pkg;

  // Default width of the signed position counter
  localparam int CountWidthDefault = 16;

  // Width of the configured limits and of the reported position
  localparam int LimitWidth = 16;

  // Register reset values
  localparam logic signed [LimitWidth-1:0] LowerReset = 16'sd0;
  localparam logic signed [LimitWidth-1:0] UpperReset = 16'sd16;
  localparam logic signed [LimitWidth-1:0] StartReset = 16'sd0;

  // Pending direction codes
  typedef enum logic [1:0] {
    DirNone = 2'd0,
    DirCw   = 2'd1,
    DirAcw  = 2'd2
  } dir_e;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    RegLower = 2'd0,
    RegUpper = 2'd1,
    RegStart = 2'd2
  } reg_idx_e;

  // Limits plus a load strobe for the start position
  typedef struct packed {
    logic signed [LimitWidth-1:0] lower;
    logic signed [LimitWidth-1:0] upper;
    logic                         load;
  } cfg_t;

  // Phase is {B, A}; clockwise runs 00, 01, 11, 10, 00
  function automatic logic [1:0] cw_next(logic [1:0] phase);
    logic [1:0] nxt;
    unique case (phase)
      2'b00:   nxt = 2'b01;
      2'b01:   nxt = 2'b11;
      2'b11:   nxt = 2'b10;
      default: nxt = 2'b00;
    endcase
    return nxt;
  endfunction

  function automatic logic [1:0] acw_next(logic [1:0] phase);
    logic [1:0] nxt;
    unique case (phase)
      2'b00:   nxt = 2'b10;
      2'b10:   nxt = 2'b11;
      2'b11:   nxt = 2'b01;
      default: nxt = 2'b00;
    endcase
    return nxt;
  endfunction

endpackage

/* rtl/qkp_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkp_cfg
// APB register file: lower limit, upper limit and start position. A start
// position write also hands a saturated load value to the counter.
// ----------------------------------------------------------------------------
module qkp_cfg #(
  parameter int CountWidth = qkp_pkg::CountWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output qkp_pkg::cfg_t         cfg_o,
  output logic [CountWidth-1:0] load_value_o
);

  localparam int LW    = qkp_pkg::LimitWidth;
  localparam int CalcW = ((CountWidth > LW) ? CountWidth : LW) + 2;
  localparam logic signed [CalcW-1:0] CntMax =
    {{(CalcW-CountWidth+1){1'b0}}, {(CountWidth-1){1'b1}}};
  localparam logic signed [CalcW-1:0] CntMin = ~CntMax;

  logic signed [LW-1:0] lower_q, upper_q, start_q;
  logic                 wr;
  logic [1:0]           idx;
  logic signed [LW-1:0] wdata;
  logic signed [CalcW-1:0] start_ext;
  logic signed [CalcW-1:0] start_fit;

  assign idx   = paddr[3:2];
  assign wr    = psel & penable & pwrite;
  assign wdata = pwdata[LW-1:0];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= qkp_pkg::LowerReset;
      upper_q <= qkp_pkg::UpperReset;
      start_q <= qkp_pkg::StartReset;
    end else if (wr) begin
      unique case (idx)
        qkp_pkg::RegLower: lower_q <= wdata;
        qkp_pkg::RegUpper: upper_q <= wdata;
        qkp_pkg::RegStart: start_q <= wdata;
        default: ;
      endcase
    end
  end

  // read mux, sign extended
  always_comb begin
    unique case (idx)
      qkp_pkg::RegLower: prdata = {{(32-LW){lower_q[LW-1]}}, lower_q};
      qkp_pkg::RegUpper: prdata = {{(32-LW){upper_q[LW-1]}}, upper_q};
      qkp_pkg::RegStart: prdata = {{(32-LW){start_q[LW-1]}}, start_q};
      default:           prdata = '0;
    endcase
  end

  // start value saturated to the counter range
  always_comb begin
    start_ext = {{(CalcW-LW){wdata[LW-1]}}, wdata};
    if (start_ext < CntMin)      start_fit = CntMin;
    else if (start_ext > CntMax) start_fit = CntMax;
    else                         start_fit = start_ext;
  end

  assign load_value_o = start_fit[CountWidth-1:0];
  assign cfg_o.lower  = lower_q;
  assign cfg_o.upper  = upper_q;
  assign cfg_o.load   = wr && (idx == qkp_pkg::RegStart);

endmodule

/* rtl/qkp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkp_step
// Transition decode and clamped count update for one quadrature sample.
// ----------------------------------------------------------------------------
module qkp_step #(
  parameter int CountWidth = qkp_pkg::CountWidthDefault
) (
  input  logic [1:0]                    prev_i,
  input  logic [1:0]                    next_i,
  input  qkp_pkg::dir_e                 dir_i,
  input  logic signed [CountWidth-1:0]  count_i,
  input  qkp_pkg::cfg_t                 cfg_i,
  output qkp_pkg::dir_e                 dir_o,
  output logic signed [CountWidth-1:0]  count_o,
  output logic                          changed_o
);

  localparam int LW    = qkp_pkg::LimitWidth;
  localparam int CalcW = ((CountWidth > LW) ? CountWidth : LW) + 2;
  localparam logic signed [CalcW-1:0] CntMax =
    {{(CalcW-CountWidth+1){1'b0}}, {(CountWidth-1){1'b1}}};
  localparam logic signed [CalcW-1:0] CntMin = ~CntMax;

  logic                    full;
  logic                    inc, dec;
  logic signed [CalcW-1:0] c_base, c_step, c_lo, c_hi, lo_ext, hi_ext;

  assign changed_o = (prev_i != next_i);
  assign full      = (next_i[0] == next_i[1]);
  assign lo_ext    = {{(CalcW-LW){cfg_i.lower[LW-1]}}, cfg_i.lower};
  assign hi_ext    = {{(CalcW-LW){cfg_i.upper[LW-1]}}, cfg_i.upper};
  assign c_base    = {{(CalcW-CountWidth){count_i[CountWidth-1]}}, count_i};

  // direction tracking
  always_comb begin
    inc   = 1'b0;
    dec   = 1'b0;
    dir_o = dir_i;
    if (changed_o) begin
      priority if (next_i == qkp_pkg::cw_next(prev_i)) begin
        priority if (dir_i == qkp_pkg::DirCw && full) inc = 1'b1;
        else if (dir_i == qkp_pkg::DirAcw)              dir_o = qkp_pkg::DirNone;
        else                                            dir_o = qkp_pkg::DirCw;
      end else if (next_i == qkp_pkg::acw_next(prev_i)) begin
        priority if (dir_i == qkp_pkg::DirAcw && full) dec = 1'b1;
        else if (dir_i == qkp_pkg::DirCw)                dir_o = qkp_pkg::DirNone;
        else                                             dir_o = qkp_pkg::DirAcw;
      end else begin
        // skipped phase: move in the armed direction on a full step
        inc = full && (dir_i == qkp_pkg::DirCw);
        dec = full && (dir_i == qkp_pkg::DirAcw);
      end
    end
  end

  // step, clamp lower then upper, then fit the counter range
  always_comb begin
    c_step = c_base;
    if (inc)      c_step = c_base + CalcW'(1);
    else if (dec) c_step = c_base - CalcW'(1);
    c_lo = (c_step < lo_ext) ? lo_ext : c_step;
    c_hi = (c_lo > hi_ext) ? hi_ext : c_lo;
    if (!changed_o)        count_o = count_i;
    else if (c_hi < CntMin) count_o = CntMin[CountWidth-1:0];
    else if (c_hi > CntMax) count_o = CntMax[CountWidth-1:0];
    else                    count_o = c_hi[CountWidth-1:0];
  end

endmodule

/* rtl/quadrature_knob_position.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_knob_position
// Quadrature decoder for a rotary knob: one sample of lines A/B per request,
// one result per request with the clamped position and the armed direction.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Payload
//  s_axis   in   tvalid/tready       tdata[0] line_a, [1] line_b
//  m_axis   out  tvalid/tready       tdata[15:0] position, [17:16] armed_direction
//  apb      in   psel/penable/pready lower_limit 0x0, upper_limit 0x4, start 0x8
//
//  One request per cycle sustained while m_axis accepts; a sample passes the sample register,
//  then the result register. Decode and state update are combinational
//  in qkp_step between those registers.
//  Reset: registers to 0 / 16 / 0, count 0, last sample 00, direction none.
//  A stalled m_axis holds its result; the sample register still fills, so
//  s_axis_tready_o drops only when both registers are full and stalled.
// ----------------------------------------------------------------------------
module quadrature_knob_position #(
  parameter int CountWidth = qkp_pkg::CountWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] line_a, [1] line_b
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] position, [17:16] armed_direction
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW    = qkp_pkg::LimitWidth;
  localparam int CalcW = ((CountWidth > LW) ? CountWidth : LW) + 2;

  qkp_pkg::cfg_t                cfg;
  logic [CountWidth-1:0]        load_value;

  logic                         s1_valid_q;
  logic [1:0]                   s1_line_q;
  logic [1:0]                   last_q;
  qkp_pkg::dir_e                dir_q, dir_d;
  logic signed [CountWidth-1:0] count_q, count_d;
  logic                         changed;
  logic                         out_valid_q;
  logic [23:0]                  out_data_q;
  logic                         adv;
  logic [CalcW-1:0]             cnt_ext;

  assign pready = 1'b1;

  qkp_cfg #(.CountWidth(CountWidth)) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .cfg_o        (cfg),
    .load_value_o (load_value)
  );

  qkp_step #(.CountWidth(CountWidth)) u_step (
    .prev_i    (last_q),
    .next_i    ({s1_line_q[1], s1_line_q[0]}),
    .dir_i     (dir_q),
    .count_i   (count_q),
    .cfg_i     (cfg),
    .dir_o     (dir_d),
    .count_o   (count_d),
    .changed_o (changed)
  );

  // pipeline flow control
  assign adv             = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || adv;

  // sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_line_q <= {s_axis_tdata_i[1], s_axis_tdata_i[0]};
    end
  end

  // decoder state; a start write loads the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 2'b00;
      dir_q   <= qkp_pkg::DirNone;
      count_q <= '0;
    end else begin
      if (adv) begin
        last_q <= s1_line_q;
        dir_q  <= dir_d;
      end
      if (cfg.load)  count_q <= load_value;
      else if (adv)  count_q <= count_d;
    end
  end

  // result register
  assign cnt_ext = {{(CalcW-CountWidth){count_d[CountWidth-1]}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {6'b0, dir_d, cnt_ext[LW-1:0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // an unchanged sample leaves the count alone
  a_hold_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !changed && !cfg.load |=> $stable(count_q))
    else $error("count moved on an unchanged sample");

  // after a changed sample the result lies within ordered limits
  a_in_limits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && changed && (cfg.lower <= cfg.upper) && (CountWidth >= LW) |=>
      ($signed(m_axis_tdata_o[15:0]) >= $past(cfg.lower)) &&
      ($signed(m_axis_tdata_o[15:0]) <= $past(cfg.upper)))
    else $error("position outside the limits");

  // input stalls only when both registers are full and output is stalled
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without backpressure");

endmodule
